/* rtl/core/wpdh_pkg.sv */
// Package for the weighted pair-distance histogram core.
// Holds payload structs, opcodes, register indexes and reset values.
// No dependencies.
package wpdh_pkg;

   localparam int NUM_PAIR_TYPES_DEFAULT = 4;
   localparam int NUM_BINS_DEFAULT       = 128;

   localparam int ACC_W  = 48;   // bin and result width, Q32.16
   localparam int DIST_W = 24;   // Q8.16
   localparam int CSR_W  = 24;

   // opcodes
   localparam logic [2:0] OP_SAMPLE      = 3'd0;
   localparam logic [2:0] OP_START_ACC   = 3'd1;
   localparam logic [2:0] OP_STOP_ACC    = 3'd2;
   localparam logic [2:0] OP_START_BLOCK = 3'd3;
   localparam logic [2:0] OP_READ_BIN    = 3'd4;

   // register indexes
   localparam logic CSR_MAX_DISTANCE      = 1'b0;
   localparam logic CSR_INVERSE_BIN_WIDTH = 1'b1;

   localparam logic [CSR_W-1:0] MAX_DISTANCE_RESET      = 24'd655360;  // 10.0
   localparam logic [CSR_W-1:0] INVERSE_BIN_WIDTH_RESET = 24'd655360;  // 1/0.1

   localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [1:0]         pair_type;
      logic [DIST_W-1:0]  distance;
      logic signed [31:0] weight;
      logic [31:0]        scale;
      logic [6:0]         read_bin;
   } req_payload_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic                    dropped;
      logic                    saturated;
   } rsp_payload_type;

endpackage

/* rtl/core/weighted_pair_distance_histogram_core.sv */
// Weighted pair-distance histogram core: instant and block histograms in
// two on-chip memories, with sample, clear, merge and read operations.
// Depends on wpdh_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   req     | in        | req_valid/ready    | wpdh_pkg::req_payload_type
//   rsp     | out       | rsp_valid/ready    | wpdh_pkg::rsp_payload_type
//   csr     | in        | csr_valid/ready    | csr_index (1b), csr_data (24b)
//
// Sequencing: one request at a time. A sample steps through bin multiply,
// check and memory read, read-modify-write and response load. A read sends
// one cell through the scale pipeline and waits for it to drain; a read
// with the row or bin out of range, and an unused opcode, go straight to
// the response. Start accumulate and start block sweep every cell. Stop
// accumulate streams every cell through the scale pipeline; each histogram
// memory has one read and one write port, and the walk issues one cell per cycle.
// Reset: a clearing pass zeroes both memories; req_ready
// stays low meanwhile, csr writes are taken at all times.
// Stalls: the response sits in an output register, so a new request is
// accepted while rsp_ready is low; a later response waits in its final
// state until that register frees.

module weighted_pair_distance_histogram_core #(
   parameter int NUM_PAIR_TYPES = wpdh_pkg::NUM_PAIR_TYPES_DEFAULT,
   parameter int NUM_BINS       = wpdh_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  wpdh_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output wpdh_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [wpdh_pkg::CSR_W-1:0]            csr_data
);

   localparam int CELLS  = NUM_PAIR_TYPES * NUM_BINS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int ACC_W  = wpdh_pkg::ACC_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_BIN   = 3'd2;
   localparam logic [2:0] ST_SCHK  = 3'd3;
   localparam logic [2:0] ST_SWR   = 3'd4;
   localparam logic [2:0] ST_WALK  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;
   localparam logic [2:0] ST_RESP  = 3'd7;

   function automatic logic [ADDR_W-1:0] cell_index(input logic [1:0] pt,
                                                    input logic [ADDR_W-1:0] bin);
      logic [ADDR_W-1:0] row;
      row = ADDR_W'(ADDR_W'(pt) * ADDR_W'(NUM_BINS));
      return ADDR_W'(row + bin);
   endfunction

   // 48-bit saturating add; flag set on clamp
   function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                              input logic signed [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return {1'b1, (s[ACC_W] ? wpdh_pkg::ACC_MIN : wpdh_pkg::ACC_MAX)};
      end
      return {1'b0, s[ACC_W-1:0]};
   endfunction

   // ---------------------------------------------------------------- control
   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       walk_ff, walk_in;
   logic                    clr_both_ff, clr_both_in;
   logic                    clr_resp_ff, clr_resp_in;
   wpdh_pkg::req_payload_type req_ff, req_in;
   logic [2*wpdh_pkg::DIST_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic signed [ACC_W-1:0] res_value_ff, res_value_in;
   logic                    res_drop_ff, res_drop_in;
   logic                    res_sat_ff, res_sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wpdh_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [wpdh_pkg::CSR_W-1:0] max_dist_ff, max_dist_in;
   logic [wpdh_pkg::CSR_W-1:0] inv_bw_ff, inv_bw_in;

   // memories
   logic signed [ACC_W-1:0] inst_mem [CELLS];
   logic signed [ACC_W-1:0] blk_mem  [CELLS];
   logic signed [ACC_W-1:0] inst_rdata_ff;
   logic signed [ACC_W-1:0] blk_rdata_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    inst_we, blk_we;
   logic [ADDR_W-1:0]       inst_waddr, blk_waddr;
   logic signed [ACC_W-1:0] inst_wdata, blk_wdata;

   // scale pipeline
   logic                    v0_ff, v0_in, v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0]       addr0_ff, addr1_ff, addr2_ff, addr3_ff;
   logic [ACC_W-1:0]        m1_ff;
   logic                    neg1_ff, neg2_ff;
   logic signed [ACC_W-1:0] add1_ff, add2_ff, add3_ff;
   logic [63:0]             plo2_ff;
   logic [ACC_W-1:0]        phi2_ff;
   logic signed [ACC_W-1:0] scl3_ff, scl3_in;
   logic                    sat3_ff, sat3_in;

   logic                    accept;
   logic                    rsp_free;
   logic [15:0]             samp_bin;
   logic                    samp_drop;
   logic [ADDR_W-1:0]       samp_idx;
   logic [ADDR_W-1:0]       read_idx;
   logic                    read_ok;
   logic                    walk_last;
   logic [ACC_W:0]          samp_sum;
   logic [ACC_W:0]          merge_sum;
   logic signed [ACC_W-1:0] p0_src;
   logic [ACC_W:0]          q2, qn2;
   logic                    hi_over2;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // sample bin: floor of the Q16.32 product
   assign samp_bin  = prod_ff[2*wpdh_pkg::DIST_W-1:32];
   assign samp_drop = (32'(req_ff.pair_type) >= NUM_PAIR_TYPES)
                      || (req_ff.distance >= max_dist_ff)
                      || (32'(samp_bin) >= NUM_BINS);
   assign samp_idx  = cell_index(req_ff.pair_type, ADDR_W'(samp_bin));
   assign read_idx  = cell_index(req_ff.pair_type, ADDR_W'(req_ff.read_bin));
   assign read_ok   = (32'(req_data.pair_type) < NUM_PAIR_TYPES)
                      && (32'(req_data.read_bin) < NUM_BINS);
   assign walk_last = (req_ff.opcode == wpdh_pkg::OP_READ_BIN)
                      || (walk_ff == ADDR_W'(CELLS - 1));
   assign samp_sum  = sat_add(inst_rdata_ff,
                              {{(ACC_W-32){req_ff.weight[31]}}, req_ff.weight});
   assign merge_sum = sat_add(add3_ff, scl3_ff);

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      clr_both_in  = clr_both_ff;
      clr_resp_in  = clr_resp_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      res_value_in = res_value_ff;
      res_drop_in  = res_drop_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      v0_in        = 1'b0;
      rd_addr      = walk_ff;
      inst_we      = 1'b0;
      inst_waddr   = walk_ff;
      inst_wdata   = '0;
      blk_we       = 1'b0;
      blk_waddr    = walk_ff;
      blk_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               res_value_in = '0;
               res_drop_in  = 1'b0;
               res_sat_in   = 1'b0;
               walk_in      = '0;
               unique case (req_data.opcode)
                  wpdh_pkg::OP_SAMPLE: state_in = ST_BIN;
                  wpdh_pkg::OP_START_ACC: begin
                     state_in    = ST_CLEAR;
                     clr_both_in = 1'b0;
                     clr_resp_in = 1'b1;
                  end
                  wpdh_pkg::OP_STOP_ACC: state_in = ST_WALK;
                  wpdh_pkg::OP_START_BLOCK: begin
                     state_in    = ST_CLEAR;
                     clr_both_in = 1'b1;
                     clr_resp_in = 1'b1;
                  end
                  wpdh_pkg::OP_READ_BIN: state_in = read_ok ? ST_WALK : ST_RESP;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            inst_we = 1'b1;
            blk_we  = clr_both_ff;
            walk_in = ADDR_W'(walk_ff + 1'b1);
            if (walk_ff == ADDR_W'(CELLS - 1)) begin
               state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_BIN: begin
            prod_in  = (2*wpdh_pkg::DIST_W)'(req_ff.distance)
                       * (2*wpdh_pkg::DIST_W)'(inv_bw_ff);
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            rd_addr = samp_idx;
            idx_in  = samp_idx;
            if (samp_drop) begin
               res_drop_in = 1'b1;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_SWR;
            end
         end
         ST_SWR: begin
            inst_we    = 1'b1;
            inst_waddr = idx_ff;
            inst_wdata = samp_sum[ACC_W-1:0];
            res_sat_in = samp_sum[ACC_W];
            state_in   = ST_RESP;
         end
         ST_WALK: begin
            v0_in   = 1'b1;
            rd_addr = (req_ff.opcode == wpdh_pkg::OP_READ_BIN) ? read_idx : walk_ff;
            walk_in = ADDR_W'(walk_ff + 1'b1);
            if (walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(v0_ff || v1_ff || v2_ff || v3_ff)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{value: res_value_ff, dropped: res_drop_ff,
                                saturated: res_sat_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // end of the scale pipeline: merge into the block bin, or return it
      if (v3_ff) begin
         if (req_ff.opcode == wpdh_pkg::OP_READ_BIN) begin
            res_value_in = scl3_ff;
            res_sat_in   = res_sat_ff || sat3_ff;
         end else begin
            blk_we     = 1'b1;
            blk_waddr  = addr3_ff;
            blk_wdata  = merge_sum[ACC_W-1:0];
            res_sat_in = res_sat_ff || sat3_ff || merge_sum[ACC_W];
         end
      end
   end

   // config registers
   always_comb begin
      max_dist_in = max_dist_ff;
      inv_bw_in   = inv_bw_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wpdh_pkg::CSR_MAX_DISTANCE:      max_dist_in = csr_data;
            wpdh_pkg::CSR_INVERSE_BIN_WIDTH: inv_bw_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         walk_ff      <= '0;
         clr_both_ff  <= 1'b1;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         max_dist_ff  <= wpdh_pkg::MAX_DISTANCE_RESET;
         inv_bw_ff    <= wpdh_pkg::INVERSE_BIN_WIDTH_RESET;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         clr_both_ff  <= clr_both_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
         v0_ff        <= v0_in;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         max_dist_ff  <= max_dist_in;
         inv_bw_ff    <= inv_bw_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prod_ff      <= prod_in;
      idx_ff       <= idx_in;
      res_value_ff <= res_value_in;
      res_drop_ff  <= res_drop_in;
      res_sat_ff   <= res_sat_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (inst_we) begin
         inst_mem[inst_waddr] <= inst_wdata;
      end
      inst_rdata_ff <= inst_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_rdata_ff <= blk_mem[rd_addr];
   end

   // ---------------------------------------------------------- scale pipeline
   // P0: read data -> magnitude; P1: split multiply; P2: shift, floor, clamp;
   // P3: merge add or result capture (above).
   assign p0_src = (req_ff.opcode == wpdh_pkg::OP_READ_BIN) ? blk_rdata_ff
                                                            : inst_rdata_ff;

   // q = (m * scale) >> 16, 49 bits wide once the high product is in range
   assign hi_over2 = (phi2_ff > ACC_W'(33'h0_8000_0000));
   assign q2  = {phi2_ff[32:0], 16'b0} + (ACC_W+1)'(plo2_ff[63:16]);
   assign qn2 = q2 + (ACC_W+1)'(|plo2_ff[15:0]);   // floor for negatives

   always_comb begin
      sat3_in = 1'b0;
      scl3_in = '0;
      if (hi_over2) begin
         sat3_in = 1'b1;
         scl3_in = neg2_ff ? wpdh_pkg::ACC_MIN : wpdh_pkg::ACC_MAX;
      end else if (!neg2_ff) begin
         if (q2 > (ACC_W+1)'(wpdh_pkg::ACC_MAX)) begin
            sat3_in = 1'b1;
            scl3_in = wpdh_pkg::ACC_MAX;
         end else begin
            scl3_in = q2[ACC_W-1:0];
         end
      end else begin
         if (qn2 > {2'b01, {(ACC_W-1){1'b0}}}) begin
            sat3_in = 1'b1;
            scl3_in = wpdh_pkg::ACC_MIN;
         end else begin
            scl3_in = -qn2[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      addr0_ff <= rd_addr;
      // P0 -> P1
      addr1_ff <= addr0_ff;
      neg1_ff  <= p0_src[ACC_W-1];
      m1_ff    <= p0_src[ACC_W-1] ? -p0_src : p0_src;
      add1_ff  <= blk_rdata_ff;
      // P1 -> P2
      addr2_ff <= addr1_ff;
      neg2_ff  <= neg1_ff;
      add2_ff  <= add1_ff;
      plo2_ff  <= 64'(m1_ff[31:0]) * 64'(req_ff.scale);
      phi2_ff  <= ACC_W'(m1_ff[ACC_W-1:32]) * ACC_W'(req_ff.scale);
      // P2 -> P3
      addr3_ff <= addr2_ff;
      add3_ff  <= add2_ff;
      scl3_ff  <= scl3_in;
      sat3_ff  <= sat3_in;
   end

endmodule

/* dv/wpdh_histogram_checker.sv */
// Response checker for the weighted pair-distance histogram core: mirrors both
// histograms and the two registers, predicts every response and compares it.
// Depends on wpdh_pkg.
module wpdh_histogram_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  wpdh_pkg::req_payload_type    req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  wpdh_pkg::rsp_payload_type    rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [wpdh_pkg::CSR_W-1:0]   csr_data,
   output int                           mismatches,
   output int                           outstanding,
   output int                           checked,
   output int                           drops,
   output int                           sats
);

   localparam int ROWS       = wpdh_pkg::NUM_PAIR_TYPES_DEFAULT;
   localparam int BINS       = wpdh_pkg::NUM_BINS_DEFAULT;
   localparam int SLOTS      = ROWS * BINS;
   localparam int OWED_DEPTH = 8;

   typedef logic signed [wpdh_pkg::ACC_W-1:0] acc_type;

   acc_type                    inst_bins [0:SLOTS-1];
   acc_type                    blk_bins  [0:SLOTS-1];
   logic [wpdh_pkg::CSR_W-1:0] cutoff;
   logic [wpdh_pkg::CSR_W-1:0] inv_width;
   logic                       step_clamped;

   // ring of predicted responses, oldest at owed_rd
   wpdh_pkg::rsp_payload_type  owed_rsp [0:OWED_DEPTH-1];
   int                         owed_rd, owed_wr, owed_n;
   wpdh_pkg::rsp_payload_type  predicted;
   wpdh_pkg::rsp_payload_type  want;
   wpdh_pkg::rsp_payload_type  got;
   int                         n_err, n_checked, n_drop, n_sat;

   function automatic acc_type clamp_sum(acc_type a, acc_type b);
      logic signed [wpdh_pkg::ACC_W:0] s;
      s = (wpdh_pkg::ACC_W+1)'(a) + (wpdh_pkg::ACC_W+1)'(b);
      if (s > wpdh_pkg::ACC_MAX) begin
         step_clamped = 1'b1;
         return wpdh_pkg::ACC_MAX;
      end
      if (s < wpdh_pkg::ACC_MIN) begin
         step_clamped = 1'b1;
         return wpdh_pkg::ACC_MIN;
      end
      return s[wpdh_pkg::ACC_W-1:0];
   endfunction

   // exact product, floor shift by 16, clamp
   function automatic acc_type scale_by(acc_type a, logic [31:0] s);
      logic signed [wpdh_pkg::ACC_W+32:0] p;
      p = (wpdh_pkg::ACC_W+33)'(a) * (wpdh_pkg::ACC_W+33)'($signed({1'b0, s}));
      p = p >>> 16;
      if (p > wpdh_pkg::ACC_MAX) begin
         step_clamped = 1'b1;
         return wpdh_pkg::ACC_MAX;
      end
      if (p < wpdh_pkg::ACC_MIN) begin
         step_clamped = 1'b1;
         return wpdh_pkg::ACC_MIN;
      end
      return p[wpdh_pkg::ACC_W-1:0];
   endfunction

   function automatic wpdh_pkg::rsp_payload_type histogram_step(
         wpdh_pkg::req_payload_type r);
      wpdh_pkg::rsp_payload_type     res;
      logic [2*wpdh_pkg::DIST_W-1:0] bin_prod;
      logic [15:0]                   bin;
      acc_type                       w;
      int                            slot;
      int                            i;
      res = '0;
      step_clamped = 1'b0;
      case (r.opcode)
         wpdh_pkg::OP_SAMPLE: begin
            bin_prod = (2*wpdh_pkg::DIST_W)'(r.distance)
                       * (2*wpdh_pkg::DIST_W)'(inv_width);
            bin = bin_prod[2*wpdh_pkg::DIST_W-1:32];
            if (int'(r.pair_type) >= ROWS || r.distance >= cutoff
                || int'(bin) >= BINS) begin
               res.dropped = 1'b1;
            end else begin
               w = wpdh_pkg::ACC_W'(r.weight);
               slot = int'(r.pair_type) * BINS + int'(bin);
               inst_bins[slot] = clamp_sum(inst_bins[slot], w);
            end
         end
         wpdh_pkg::OP_START_ACC: begin
            for (i = 0; i < SLOTS; i++) inst_bins[i] = '0;
         end
         wpdh_pkg::OP_STOP_ACC: begin
            for (i = 0; i < SLOTS; i++)
               blk_bins[i] = clamp_sum(blk_bins[i], scale_by(inst_bins[i], r.scale));
         end
         wpdh_pkg::OP_START_BLOCK: begin
            for (i = 0; i < SLOTS; i++) begin
               inst_bins[i] = '0;
               blk_bins[i]  = '0;
            end
         end
         wpdh_pkg::OP_READ_BIN: begin
            if (int'(r.pair_type) < ROWS && int'(r.read_bin) < BINS)
               res.value = scale_by(blk_bins[int'(r.pair_type) * BINS
                                             + int'(r.read_bin)], r.scale);
         end
         default: ;
      endcase
      res.saturated = step_clamped;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            inst_bins[i] = '0;
            blk_bins[i]  = '0;
         end
         cutoff    = wpdh_pkg::MAX_DISTANCE_RESET;
         inv_width = wpdh_pkg::INVERSE_BIN_WIDTH_RESET;
         owed_rd = 0;
         owed_wr = 0;
         owed_n = 0;
         n_err = 0;
         n_checked = 0;
         n_drop = 0;
         n_sat = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == wpdh_pkg::CSR_MAX_DISTANCE) cutoff = csr_data;
            else inv_width = csr_data;
         end
         // compare first, so a response never meets the request of this edge
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (owed_n == 0) begin
               $error("response with no request owed");
               n_err++;
            end else begin
               want = owed_rsp[owed_rd];
               owed_rd = (owed_rd + 1) % OWED_DEPTH;
               owed_n--;
               n_checked++;
               if (want.dropped) n_drop++;
               if (want.saturated) n_sat++;
               if (got.value !== want.value) begin
                  $error("value: expected %0d, got %0d", $signed(want.value),
                         $signed(got.value));
                  n_err++;
               end
               if (got.dropped !== want.dropped) begin
                  $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                  n_err++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated,
                         got.saturated);
                  n_err++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = histogram_step(req_data);
            if (owed_n == OWED_DEPTH) begin
               $error("more than %0d responses owed", OWED_DEPTH);
               n_err++;
            end else begin
               owed_rsp[owed_wr] = predicted;
               owed_wr = (owed_wr + 1) % OWED_DEPTH;
               owed_n++;
            end
         end
      end
      outstanding <= owed_n;
      mismatches  <= n_err;
      checked     <= n_checked;
      drops       <= n_drop;
      sats        <= n_sat;
   end

endmodule

/* dv/tb_weighted_pair_distance_histogram_core.sv */
// Top of the histogram core testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict.
// Depends on wpdh_pkg, weighted_pair_distance_histogram_core, wpdh_histogram_checker.
module tb_weighted_pair_distance_histogram_core;

   localparam int BINS            = wpdh_pkg::NUM_BINS_DEFAULT;
   // Longest quiet stretch of a correct run is the reset clearing pass or a
   // merge sweep or the long hold-off; take several times that.
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HIT_MAX         = 16;
   // opcodes the block leaves undefined: must answer all-zero and change nothing
   localparam logic [2:0] OP_SPARE_LO = wpdh_pkg::OP_READ_BIN + 3'd1;
   localparam logic [2:0] OP_SPARE_HI = 3'h7;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   wpdh_pkg::req_payload_type   req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   wpdh_pkg::rsp_payload_type   rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_index = 1'b0;
   logic [wpdh_pkg::CSR_W-1:0]  csr_data = '0;

   int mismatches, outstanding, checked, drops, sats;

   int                          items_sent = 0;
   int                          directed_items = 0;
   int                          burst_mode = 0;      // 1: neither side idles
   int                          hold_off_reqs = 0;   // bumped (NBA) to ask for a long rsp stall
   int                          holds_served = 0;
   int                          quiet_cycles = 0;
   logic [wpdh_pkg::CSR_W-1:0]  cfg_inv_width = wpdh_pkg::INVERSE_BIN_WIDTH_RESET;

   // cells sampled in the current sequence, so reads hit populated bins
   logic [1:0]        hit_pt  [0:HIT_MAX-1];
   logic [6:0]        hit_bin [0:HIT_MAX-1];
   int                hit_n = 0;

   always #6 clock = ~clock;

   weighted_pair_distance_histogram_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   wpdh_histogram_checker histogram_watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .drops       (drops),
      .sats        (sats)
   );

   function automatic wpdh_pkg::req_payload_type make_req(logic [2:0] op,
                                                          logic [1:0] pt,
                                                          logic [23:0] pair_dist,
                                                          logic [31:0] w,
                                                          logic [31:0] s,
                                                          logic [6:0] rb);
      wpdh_pkg::req_payload_type p;
      p.opcode    = op;
      p.pair_type = pt;
      p.distance  = pair_dist;
      p.weight    = w;
      p.scale     = s;
      p.read_bin  = rb;
      return p;
   endfunction

   // all fields random except the opcode
   function automatic wpdh_pkg::req_payload_type random_req(logic [2:0] op);
      return make_req(op, 2'($urandom), 24'($urandom), $urandom, $urandom,
                      7'($urandom));
   endfunction

   // extremes, small signed values around zero, and full-range noise
   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   // zero, all ones (clamps large bins), 1.0, small, full range
   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2, 3: return 32'h0001_0000;
         4: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   // One request: random idle gap (none in burst mode), then hold valid with a
   // fixed payload until accepted. Valid stays high on return so back-to-back
   // requests never drop it within one step.
   task automatic send(input wpdh_pkg::req_payload_type p);
      int gap;
      gap = (burst_mode != 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Sender pause: lower valid and wait for every owed response. The first
   // edge lets the checker's count catch up with the last accepted request.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [wpdh_pkg::CSR_W-1:0] md,
                             input logic [wpdh_pkg::CSR_W-1:0] ibw);
      csr_valid <= 1'b1;
      csr_index <= wpdh_pkg::CSR_MAX_DISTANCE;
      csr_data  <= md;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= wpdh_pkg::CSR_INVERSE_BIN_WIDTH;
      csr_data  <= ibw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cfg_inv_width = ibw;
   endtask

   // Sample aimed at a chosen bin (a few past the top to hit the range drop):
   // distance ~ (bin + frac) / inverse_bin_width. One in five is plain noise.
   task automatic aimed_sample();
      logic [1:0]  pt;
      logic [23:0] sample_dist;
      logic [63:0] num, q;
      logic [47:0] prod;
      pt = 2'($urandom);
      if ($urandom_range(0, 4) == 0 || cfg_inv_width == 0) begin
         sample_dist = 24'($urandom);
      end else begin
         num  = {16'd0, 16'($urandom_range(0, BINS + 3)), 32'($urandom)};
         q    = num / 64'(cfg_inv_width);
         sample_dist = (q > 64'hFF_FFFF) ? 24'($urandom) : q[23:0];
      end
      prod = 48'(sample_dist) * 48'(cfg_inv_width);
      if (hit_n < HIT_MAX && int'(prod[47:32]) < BINS) begin
         hit_pt[hit_n]  = pt;
         hit_bin[hit_n] = prod[38:32];
         hit_n++;
      end
      send(make_req(wpdh_pkg::OP_SAMPLE, pt, sample_dist, pick_weight(), $urandom,
                    $urandom));
   endtask

   // Mostly a well-formed accumulation block: optional start block, start
   // accumulate, samples, stop accumulate, reads. Some sequences are noise.
   task automatic run_sequence();
      int         n, k, j;
      logic [1:0] pt;
      logic [6:0] rb;
      burst_mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
      hit_n = 0;
      if ($urandom_range(0, 9) < 2) begin
         n = $urandom_range(1, 4);
         for (k = 0; k < n; k++)
            send(random_req(3'($urandom)));
      end else begin
         if ($urandom_range(0, 3) == 0)
            send(random_req(wpdh_pkg::OP_START_BLOCK));
         // occasionally skip the clear so instant bins carry over
         if ($urandom_range(0, 4) != 0)
            send(random_req(wpdh_pkg::OP_START_ACC));
         n = $urandom_range(3, 12);
         for (k = 0; k < n; k++) aimed_sample();
         send(make_req(wpdh_pkg::OP_STOP_ACC, 2'($urandom), 24'($urandom), $urandom,
                       pick_scale(), 7'($urandom)));
         n = $urandom_range(1, 5);
         for (k = 0; k < n; k++) begin
            if (hit_n != 0 && $urandom_range(0, 9) < 7) begin
               j  = $urandom_range(0, hit_n - 1);
               pt = hit_pt[j];
               rb = hit_bin[j];
            end else begin
               pt = 2'($urandom);
               rb = 7'($urandom);
            end
            send(make_req(wpdh_pkg::OP_READ_BIN, pt, 24'($urandom), $urandom,
                          pick_scale(), rb));
         end
      end
   endtask

   // Response side: random stall per response, and on demand one long
   // hold-off counted here so the core backs up and stalls req_ready.
   initial begin : rsp_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_reqs != holds_served) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = (burst_mode != 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && hold_off_reqs == holds_served) @(posedge clock);
      end
   end

   // Watchdog: any handshake on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d responses owed",
                  quiet_cycles, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                         phase, quota, quota_end, k, settings;
      logic [wpdh_pkg::CSR_W-1:0] md, ibw;
      settings = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, reset register values (cutoff 10.0, 10 bins per unit)
      // bin 0 at the largest weight, twice, so the merge below clamps
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd0, 24'd0, 32'h7FFF_FFFF, 32'h0, 7'd0));
      // just under the cutoff: last populated bin, most negative weight
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd3, 24'd655359, 32'h8000_0000, 32'h0, 7'd0));
      // exactly at the cutoff: dropped
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd1, 24'd655360, 32'h0001_0000, 32'h0, 7'd0));
      // largest distance: dropped
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd2, 24'hFF_FFFF, 32'h0001_0000, 32'h0, 7'd0));
      // one bin width: lands in bin 1
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd2, 24'd6554, 32'h0000_0001, 32'h0, 7'd0));
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd0, 24'd0, 32'h7FFF_FFFF, 32'h0, 7'd0));
      // block still empty
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd0, 24'd0, 32'h0, 32'h0001_0000, 7'd0));
      // merge with the largest scale: product clamps
      send(make_req(wpdh_pkg::OP_STOP_ACC, 2'd0, 24'd0, 32'h0, 32'hFFFF_FFFF, 7'd0));
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd0, 24'd0, 32'h0, 32'hFFFF_FFFF, 7'd0));
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd3, 24'd0, 32'h0, 32'h0001_0000, 7'd99));
      // top bin, zero scale
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd3, 24'd0, 32'h0, 32'h0, 7'h7F));
      // tiny scale: product floors to zero
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd2, 24'd0, 32'h0, 32'h0000_0001, 7'd1));
      // second merge: block sum clamps
      send(make_req(wpdh_pkg::OP_STOP_ACC, 2'd0, 24'd0, 32'h0, 32'hFFFF_FFFF, 7'd0));
      send(make_req(wpdh_pkg::OP_START_ACC, 2'd0, 24'd0, 32'h0, 32'h0, 7'd0));
      // instant cleared: merge leaves block as is
      send(make_req(wpdh_pkg::OP_STOP_ACC, 2'd0, 24'd0, 32'h0, 32'h0001_0000, 7'd0));
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd0, 24'd0, 32'h0, 32'h0001_0000, 7'd0));
      // undefined opcodes with every other field all ones
      for (k = int'(OP_SPARE_LO); k <= int'(OP_SPARE_HI); k++)
         send(make_req(3'(k), 2'b11, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F));
      send(make_req(wpdh_pkg::OP_START_BLOCK, 2'd0, 24'd0, 32'h0, 32'h0, 7'd0));
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd0, 24'd0, 32'h0, 32'hFFFF_FFFF, 7'd0));
      // weight -1 times 0.5 must round toward minus infinity
      send(make_req(wpdh_pkg::OP_SAMPLE, 2'd1, 24'd0, 32'hFFFF_FFFF, 32'h0, 7'd0));
      send(make_req(wpdh_pkg::OP_STOP_ACC, 2'd0, 24'd0, 32'h0, 32'h0000_8000, 7'd0));
      send(make_req(wpdh_pkg::OP_READ_BIN, 2'd1, 24'd0, 32'h0, 32'h0001_0000, 7'd0));
      directed_items = items_sent;
      wait_all_responses();

      // ---- random part, one register setting per phase, written while idle
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               md = wpdh_pkg::MAX_DISTANCE_RESET;
               ibw = wpdh_pkg::INVERSE_BIN_WIDTH_RESET;
               quota = 80;
            end
            1: begin
               md = 24'hFF_FFFF;
               ibw = 24'hFF_FFFF;
               quota = 80;
            end
            2: begin
               // zero cutoff: every sample dropped; zero width factor: bin 0
               md = 24'h0;
               ibw = 24'h0;
               quota = 30;
            end
            3: begin
               md = 24'($urandom);
               ibw = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(32'h1000, 32'h40_0000))
                                                 : 24'($urandom);
               quota = 100;
            end
            default: begin
               // bin = integer part of the distance, upper half out of range
               md = 24'hFF_FFFF;
               ibw = 24'h01_0000;
               quota = 90;
            end
         endcase
         set_config(md, ibw);
         settings++;
         quota_end = items_sent + quota;
         if (phase == 1) begin
            // long response hold-off while requests keep coming back to back
            hold_off_reqs <= hold_off_reqs + 1;
            burst_mode = 1;
            hit_n = 0;
            for (k = 0; k < 12; k++) aimed_sample();
            wait_all_responses();
         end
         while (items_sent < quota_end) run_sequence();
         wait_all_responses();
      end

      // drain margin, then the verdict
      repeat (20) @(posedge clock);
      $display("Covered %0d requests (%0d directed) over %0d register settings,",
               items_sent, directed_items, settings);
      $display("with a long response hold-off; %0d responses checked, %0d dropped, %0d clamped.",
               checked, drops, sats);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
